>>> hw/rtl/rjtb_pkg.sv
// Shared widths and codes for the range jump-table builder.
// No dependencies; used by rjtb_range_mem and range_jump_table_builder.
package rjtb_pkg;

	localparam int IDX_W   = 11;
	localparam int CNT_W   = 12;
	localparam int RANGE_W = 16;

	localparam logic [CNT_W-1:0] NONE_DOWN = {CNT_W{1'b1}};

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [RANGE_W-1:0] range_t;
	typedef logic [CNT_W-1:0]   count_t;

endpackage

>>> hw/rtl/rjtb_range_mem.sv
// Range store: one write port, one read port with registered read data.
// Depends on rjtb_pkg for the range type.
module rjtb_range_mem #(
	parameter int DEPTH = 2048
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  rjtb_pkg::range_t           wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output rjtb_pkg::range_t           rd_data
);

	rjtb_pkg::range_t mem_q [DEPTH];
	rjtb_pkg::range_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/range_jump_table_builder.sv
// Range jump-table builder: range store plus a sequencer that scans it with one compare pair.
// Depends on rjtb_pkg and rjtb_range_mem. Load: written to the store, no result.
// Query out of range: done in the cycle after the transfer. Query in range: read the reference
// entry (ST_REF), scan up (ST_UP), then down (ST_DN), one store read a cycle; each scan stops
// once both entries are found or its range ends; done rises after the down scan. busy drops as
// done rises, so the next transfer may follow at once. Reset clears sequencer, count and strobe.
module range_jump_table_builder #(
	parameter int MAX_POINTS = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [rjtb_pkg::IDX_W-1:0]         point_index,
	input  logic [rjtb_pkg::RANGE_W-1:0]       range_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rjtb_pkg::CNT_W-1:0]         cfg_data,
	output logic                               done,
	output logic [rjtb_pkg::CNT_W-1:0]         up_smaller,
	output logic [rjtb_pkg::CNT_W-1:0]         up_bigger,
	output logic signed [rjtb_pkg::CNT_W-1:0]  down_smaller,
	output logic signed [rjtb_pkg::CNT_W-1:0]  down_bigger,
	output logic                               index_error
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = rjtb_pkg::CNT_W;
	localparam int IW = rjtb_pkg::IDX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_REF  = 2'd1;
	localparam logic [1:0] ST_UP   = 2'd2;
	localparam logic [1:0] ST_DN   = 2'd3;

	logic [1:0]        state_q;
	rjtb_pkg::count_t  count_q;
	rjtb_pkg::count_t  eff_cnt;
	rjtb_pkg::count_t  idx_q;
	rjtb_pkg::count_t  cur_q;
	rjtb_pkg::count_t  pidx_q;
	logic              pend_q;
	rjtb_pkg::range_t  ref_q;
	rjtb_pkg::range_t  rd_data;

	rjtb_pkg::count_t  us_q, ub_q, ds_q, db_q;
	logic              fus_q, fub_q, fds_q, fdb_q;
	rjtb_pkg::count_t  us_n, ub_n, ds_n, db_n;
	logic              fus_n, fub_n, fds_n, fdb_n;

	logic              done_q;
	rjtb_pkg::count_t  res_us_q, res_ub_q, res_ds_q, res_db_q;
	logic              res_err_q;

	logic              accept, is_load, is_query, query_bad;
	logic              lt, gt, issue_up, issue_dn;
	rjtb_pkg::count_t  idx_ext, rd_idx;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [AW+CW-1:0]  rd_wide;
	logic [AW+IW-1:0]  wr_wide;
	logic              wr_en;

	// Saturate the count to the store depth
	always_comb begin
		if (32'(count_q) > 32'(MAX_POINTS)) begin
			eff_cnt = CW'(MAX_POINTS);
		end else begin
			eff_cnt = count_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign is_load   = accept && (req_type == rjtb_pkg::REQ_LOAD);
	assign is_query  = accept && (req_type == rjtb_pkg::REQ_QUERY);
	assign idx_ext   = {1'b0, point_index};
	assign query_bad = is_query && !(idx_ext < eff_cnt);

	// Shared compare pair on the entry read in the previous cycle
	assign lt = pend_q && (rd_data < ref_q);
	assign gt = pend_q && (rd_data > ref_q);

	always_comb begin
		us_n  = us_q;
		ub_n  = ub_q;
		ds_n  = ds_q;
		db_n  = db_q;
		fus_n = fus_q;
		fub_n = fub_q;
		fds_n = fds_q;
		fdb_n = fdb_q;
		// Seed the entries with their "none found" values on an in-range query transfer
		if ((state_q == ST_IDLE) && is_query && !query_bad) begin
			us_n  = eff_cnt;
			ub_n  = eff_cnt;
			ds_n  = rjtb_pkg::NONE_DOWN;
			db_n  = rjtb_pkg::NONE_DOWN;
			fus_n = 1'b0;
			fub_n = 1'b0;
			fds_n = 1'b0;
			fdb_n = 1'b0;
		end
		if (state_q == ST_UP) begin
			if (lt && !fus_q) begin
				us_n  = pidx_q;
				fus_n = 1'b1;
			end
			if (gt && !fub_q) begin
				ub_n  = pidx_q;
				fub_n = 1'b1;
			end
		end
		if (state_q == ST_DN) begin
			if (lt && !fds_q) begin
				ds_n  = pidx_q;
				fds_n = 1'b1;
			end
			if (gt && !fdb_q) begin
				db_n  = pidx_q;
				fdb_n = 1'b1;
			end
		end
	end

	assign issue_up = (state_q == ST_UP) && (cur_q < eff_cnt) && !(fus_n && fub_n);
	assign issue_dn = (state_q == ST_DN) && (cur_q != '0) && !(fds_n && fdb_n);

	always_comb begin
		case (state_q)
			ST_IDLE: rd_idx = idx_ext;
			ST_DN:   rd_idx = CW'(cur_q - 1'b1);
			default: rd_idx = cur_q;
		endcase
	end

	assign rd_wide = {{AW{1'b0}}, rd_idx};
	assign rd_addr = rd_wide[AW-1:0];
	assign wr_wide = {{AW{1'b0}}, point_index};
	assign wr_addr = wr_wide[AW-1:0];
	// Drop loads beyond the store
	assign wr_en   = is_load && (32'(point_index) < 32'(MAX_POINTS));

	rjtb_range_mem #(
		.DEPTH(MAX_POINTS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(range_value),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			fus_q   <= 1'b0;
			fub_q   <= 1'b0;
			fds_q   <= 1'b0;
			fdb_q   <= 1'b0;
		end else begin
			done_q <= query_bad || ((state_q == ST_DN) && !issue_dn);
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			fus_q <= fus_n;
			fub_q <= fub_n;
			fds_q <= fds_n;
			fdb_q <= fdb_n;
			case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (is_query && !query_bad) begin
						state_q <= ST_REF;
					end
				end
				ST_REF: begin
					state_q <= ST_UP;
				end
				ST_UP: begin
					pend_q <= issue_up;
					if (!issue_up) begin
						state_q <= ST_DN;
					end
				end
				ST_DN: begin
					pend_q <= issue_dn;
					if (!issue_dn) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed
	always_ff @(posedge clk) begin
		us_q   <= us_n;
		ub_q   <= ub_n;
		ds_q   <= ds_n;
		db_q   <= db_n;
		pidx_q <= rd_idx;
		case (state_q)
			ST_IDLE: begin
				if (query_bad) begin
					res_us_q  <= '0;
					res_ub_q  <= '0;
					res_ds_q  <= '0;
					res_db_q  <= '0;
					res_err_q <= 1'b1;
				end else if (is_query) begin
					idx_q <= idx_ext;
				end
			end
			ST_REF: begin
				ref_q <= rd_data;
				cur_q <= CW'(idx_q + 1'b1);
			end
			ST_UP: begin
				if (issue_up) begin
					cur_q <= CW'(cur_q + 1'b1);
				end else begin
					cur_q <= idx_q;
				end
			end
			ST_DN: begin
				if (issue_dn) begin
					cur_q <= CW'(cur_q - 1'b1);
				end else begin
					res_us_q  <= us_n;
					res_ub_q  <= ub_n;
					res_ds_q  <= ds_n;
					res_db_q  <= db_n;
					res_err_q <= 1'b0;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign done         = done_q;
	assign up_smaller   = res_us_q;
	assign up_bigger    = res_ub_q;
	assign down_smaller = res_ds_q;
	assign down_bigger  = res_db_q;
	assign index_error  = res_err_q;

endmodule

>>> dv/rjtb_checker.sv
// Checker for the range jump-table builder: watches the command, count-write and result channels.
// Keeps its own copy of the range store and count, and compares each result with the oldest one due.
// Depends on rjtb_pkg for widths, request codes and the "none below" marker.
module rjtb_checker #(
	parameter int MAX_POINTS = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic                               req_type,
	input  logic [rjtb_pkg::IDX_W-1:0]         point_index,
	input  logic [rjtb_pkg::RANGE_W-1:0]       range_value,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [rjtb_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               done,
	input  logic [rjtb_pkg::CNT_W-1:0]         up_smaller,
	input  logic [rjtb_pkg::CNT_W-1:0]         up_bigger,
	input  logic signed [rjtb_pkg::CNT_W-1:0]  down_smaller,
	input  logic signed [rjtb_pkg::CNT_W-1:0]  down_bigger,
	input  logic                               index_error,
	output int                                 fail_count,
	output int                                 outstanding,
	output int                                 load_count,
	output int                                 query_count,
	output int                                 error_count,
	output int                                 cfg_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rjtb_pkg::count_t up_smaller;
		rjtb_pkg::count_t up_bigger;
		rjtb_pkg::count_t down_smaller;
		rjtb_pkg::count_t down_bigger;
		logic             index_error;
	} jump_entry_t;

	rjtb_pkg::range_t range_mem [MAX_POINTS];
	rjtb_pkg::count_t point_count = '0;
	jump_entry_t      expected_jumps [$];
	jump_entry_t      want;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		load_count  = 0;
		query_count = 0;
		error_count = 0;
		cfg_count   = 0;
	end

	// Jump entries for one point, from the current store and count.
	function automatic jump_entry_t jump_lookup(input logic [rjtb_pkg::IDX_W-1:0] idx);
		int               n;
		int               j;
		rjtb_pkg::range_t r;
		jump_entry_t      e;
		n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
		e = '0;
		if (int'(idx) >= n) begin
			e.index_error = 1'b1;
			return e;
		end
		r              = range_mem[idx];
		e.up_smaller   = rjtb_pkg::count_t'(n);
		e.up_bigger    = rjtb_pkg::count_t'(n);
		e.down_smaller = rjtb_pkg::NONE_DOWN;
		e.down_bigger  = rjtb_pkg::NONE_DOWN;
		// walk towards the point so the last hit is the nearest; equal ranges never hit
		for (j = n - 1; j > int'(idx); j--) begin
			if (range_mem[j] < r)
				e.up_smaller = rjtb_pkg::count_t'(j);
			if (range_mem[j] > r)
				e.up_bigger = rjtb_pkg::count_t'(j);
		end
		for (j = 0; j < int'(idx); j++) begin
			if (range_mem[j] < r)
				e.down_smaller = rjtb_pkg::count_t'(j);
			if (range_mem[j] > r)
				e.down_bigger = rjtb_pkg::count_t'(j);
		end
		return e;
	endfunction

	task automatic check_field(input string field, input int wanted, input int got);
		if (got != wanted) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// retire the finished query before taking a new one on the same edge
			if (done) begin
				if (expected_jumps.size() == 0) begin
					$display("%0t: result with no query outstanding, up_smaller %0d",
						$time, up_smaller);
					fail_count++;
				end else begin
					want = expected_jumps.pop_front();
					check_field("up_smaller", int'(want.up_smaller), int'(up_smaller));
					check_field("up_bigger", int'(want.up_bigger), int'(up_bigger));
					check_field("down_smaller", int'($signed(want.down_smaller)),
						int'(down_smaller));
					check_field("down_bigger", int'($signed(want.down_bigger)),
						int'(down_bigger));
					check_field("index_error", int'(want.index_error), int'(index_error));
				end
			end
			if (cfg_valid && cfg_ready) begin
				point_count = cfg_data;
				cfg_count++;
			end
			if (start && !busy) begin
				if (req_type == rjtb_pkg::REQ_LOAD) begin
					if (point_index < MAX_POINTS)
						range_mem[point_index] = range_value;
					load_count++;
				end else begin
					want = jump_lookup(point_index);
					// append to the tail of the queue
					expected_jumps = {expected_jumps, want};
					query_count++;
					if (want.index_error)
						error_count++;
				end
			end
			outstanding <= expected_jumps.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// Top of the range jump-table builder bench: clock, reset, command and count-write stimulus.
// Instantiates range_jump_table_builder and rjtb_checker; uses rjtb_pkg codes and types.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_POINTS  = 2048;
	localparam int FILL_POINTS = 64;
	localparam int QUIET_LIMIT = 20000;
	localparam int IDX_W       = rjtb_pkg::IDX_W;
	localparam int CNT_W       = rjtb_pkg::CNT_W;

	typedef rjtb_pkg::range_t range_t;
	typedef rjtb_pkg::count_t count_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 req_type    = rjtb_pkg::REQ_LOAD;
	logic [IDX_W-1:0]     point_index = '0;
	range_t               range_value = '0;
	logic                 cfg_valid   = 1'b0;
	count_t               cfg_data    = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 done;
	count_t               up_smaller;
	count_t               up_bigger;
	logic signed [CNT_W-1:0] down_smaller;
	logic signed [CNT_W-1:0] down_bigger;
	logic                 index_error;

	int fail_count;
	int outstanding;
	int load_count;
	int query_count;
	int error_count;
	int cfg_count;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	range_jump_table_builder #(
		.MAX_POINTS(MAX_POINTS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.point_index (point_index),
		.range_value (range_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.up_smaller  (up_smaller),
		.up_bigger   (up_bigger),
		.down_smaller(down_smaller),
		.down_bigger (down_bigger),
		.index_error (index_error)
	);

	rjtb_checker #(
		.MAX_POINTS(MAX_POINTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.point_index (point_index),
		.range_value (range_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.up_smaller  (up_smaller),
		.up_bigger   (up_bigger),
		.down_smaller(down_smaller),
		.down_bigger (down_bigger),
		.index_error (index_error),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.load_count  (load_count),
		.query_count (query_count),
		.error_count (error_count),
		.cfg_count   (cfg_count)
	);

	// Count cycles with no transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Ranges biased towards the extremes and a narrow band, so equal neighbours are common.
	function automatic range_t pick_range();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		if (pick <= 4)
			return range_t'(100 + $urandom_range(7));
		return range_t'($urandom_range(65535));
	endfunction

	task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx, input range_t val,
			input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start       <= 1'b1;
		req_type    <= kind;
		point_index <= idx;
		range_value <= val;
		do @(posedge clk); while (busy);
	endtask

	// Hold off the sender until every query has answered.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_count(input count_t value);
		drain_results();
		// let a trailing load finish before touching the count
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input count_t count, input int n_items, input int idle_pct,
			input bit mid_drain);
		int               n;
		int               pick;
		logic             kind;
		logic [IDX_W-1:0] idx;
		write_count(count);
		n = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
		for (int i = 0; i < n_items; i++) begin
			if (mid_drain && i == n_items / 2)
				drain_results();
			kind = ($urandom_range(99) < 35) ? rjtb_pkg::REQ_LOAD : rjtb_pkg::REQ_QUERY;
			pick = $urandom_range(9);
			if (n > 0 && pick < 7)
				idx = IDX_W'($urandom_range(n - 1));
			else if (pick == 7)
				idx = (n > 0) ? IDX_W'(n - 1) : '0;
			else if (pick == 8 && n < MAX_POINTS)
				idx = IDX_W'(n);
			else
				idx = IDX_W'($urandom_range(MAX_POINTS - 1));
			send_item(kind, idx, pick_range(), idle_pct);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count is zero after reset: every query is out of range
		send_item(rjtb_pkg::REQ_QUERY, '0, '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, '1, '1, 0);

		// fill the low block; random counts stay inside it so no scan reads an unloaded entry
		for (int i = 0; i < FILL_POINTS; i++)
			send_item(rjtb_pkg::REQ_LOAD, IDX_W'(i), pick_range(), 9);

		write_count(count_t'(FILL_POINTS));
		send_item(rjtb_pkg::REQ_LOAD, '0, '0, 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(FILL_POINTS - 1), '1, 0);
		send_item(rjtb_pkg::REQ_QUERY, '0, '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(FILL_POINTS - 1), '0, 0);
		// equal pair in the middle of a falling run: the search must step over it
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(9), range_t'(501), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(10), range_t'(500), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(11), range_t'(500), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(12), range_t'(499), 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(10), '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(11), '0, 0);

		// top of the store: queries on the last three points find their entries in these five
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(MAX_POINTS - 5), range_t'(1000), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(MAX_POINTS - 4), range_t'(50), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(MAX_POINTS - 3), range_t'(900), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(MAX_POINTS - 2), range_t'(100), 0);
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(MAX_POINTS - 1), range_t'(500), 0);

		write_count(count_t'(MAX_POINTS));
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 1), '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 2), '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 3), '0, 0);

		// count above the store size saturates
		write_count('1);
		send_item(rjtb_pkg::REQ_QUERY, '1, '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 3), '0, 0);
		write_count(count_t'($urandom_range(MAX_POINTS + 1, 4094)));
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 2), '0, 0);

		write_count(count_t'(MAX_POINTS - 1));
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(MAX_POINTS - 2), '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, '1, '0, 0);

		write_count(count_t'(1));
		send_item(rjtb_pkg::REQ_QUERY, '0, '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(1), '0, 0);

		write_count(count_t'(2));
		send_item(rjtb_pkg::REQ_LOAD, IDX_W'(1), '1, 0);
		send_item(rjtb_pkg::REQ_QUERY, '0, '0, 0);
		send_item(rjtb_pkg::REQ_QUERY, IDX_W'(1), '0, 0);

		// sender idles seldom, then often, then never
		random_phase(count_t'($urandom_range(2, 40)), 20, 9, 1'b0);
		random_phase('0, 10, 9, 1'b0);
		random_phase(count_t'(FILL_POINTS), 15, 9, 1'b1);
		random_phase(count_t'($urandom_range(2, FILL_POINTS)), 20, 9, 1'b1);
		random_phase(count_t'(1), 10, 80, 1'b0);
		random_phase(count_t'($urandom_range(2, FILL_POINTS)), 20, 80, 1'b0);
		random_phase(count_t'(FILL_POINTS), 15, 80, 1'b0);
		random_phase(count_t'($urandom_range(2, 40)), 20, 80, 1'b0);
		random_phase(count_t'($urandom_range(2, FILL_POINTS)), 20, 0, 1'b0);
		random_phase(count_t'(FILL_POINTS - 1), 15, 0, 1'b0);
		random_phase(count_t'($urandom_range(2, FILL_POINTS)), 30, 0, 1'b1);

		drain_results();
		repeat (16) @(posedge clk);

		$display("covered %0d loads and %0d queries (%0d out of range) over %0d count writes",
			load_count, query_count, error_count, cfg_count);
		$display("counts from 0 to full scale and above, sender idling at 0, 9 and 80 percent");
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
